### hw/rtl/eeq_pkg.sv
package eeq_pkg;

  localparam int unsigned EEQ_DEPTH = 16;
  // most results a single scan may report
  localparam int unsigned RES_LIMIT = 16;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned LIFE_W = 16;
  localparam int unsigned AGE_W  = 17;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_SCAN = 2'd2;
  // unused code, ignored by the block
  localparam logic [1:0] KIND_RSVD = 2'd3;

  localparam logic STATUS_EXPIRED = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
    logic [LIFE_W-1:0]        lifetime;
  } eeq_in_t;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] value_res;
    logic                     last;
  } eeq_res_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [LIFE_W-1:0] lifetime;
    logic [AGE_W-1:0]  age;
  } eeq_entry_t;

  localparam int unsigned ENTRY_W = $bits(eeq_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCAN
  } eeq_state_e;

endpackage

### hw/rtl/eeq_ram.sv
module eeq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/expiring_entry_queue.sv
// Queue of up to DEPTH entries kept in insertion order, each with a value, a
// lifetime and an age in seconds. An add leaves busy low; a full queue drops
// the add and reports it in the next cycle. A tick or a scan walks the held
// entries through the single port pair of the entry RAM, one entry per cycle,
// and keeps busy high until the walk is done. A scan reports each removed
// value as a one-cycle strobe on res_valid_o, at most one per cycle and at
// most 16 per scan, the last one flagged; the final result appears in the
// first cycle in which busy is low again. Results cannot be held off: the
// receiver must take every strobe as it comes.
module expiring_entry_queue
  import eeq_pkg::*;
#(
  parameter int unsigned DEPTH = EEQ_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  eeq_in_t  in_i,
  output logic     res_valid_o,
  output eeq_res_t res_o
);

  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned NresW = $clog2(RES_LIMIT + 1);

  eeq_state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic [CntW-1:0]  keep_q, keep_d;
  logic             proc_q, proc_d;
  logic [IdxW-1:0]  proc_idx_q, proc_idx_d;
  logic [NresW-1:0] nres_q, nres_d;
  logic             pend_vld_q, pend_vld_d;
  logic [DATA_W-1:0] pend_val_q, pend_val_d;
  logic             res_vld_q, res_vld_d;
  eeq_res_t         res_q, res_d;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  eeq_entry_t       ram_wdata;
  eeq_entry_t       ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  logic accept, issue, walk_done, expired;

  assign accept    = start && (state_q == ST_IDLE);
  assign issue     = rd_idx_q < cnt_q;
  assign walk_done = !issue && !proc_q;
  assign ram_rdata = eeq_entry_t'(ram_rbits);
  assign expired   = ram_rdata.age > {1'b0, ram_rdata.lifetime};

  eeq_ram #(
    .Width(ENTRY_W),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx_q[IdxW-1:0]),
    .rdata_o(ram_rbits)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_i.kind == KIND_TICK) begin
          state_d = ST_TICK;
        end else if (accept && in_i.kind == KIND_SCAN) begin
          state_d = ST_SCAN;
        end
      end
      ST_TICK, ST_SCAN: begin
        if (walk_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d      = cnt_q;
    rd_idx_d   = rd_idx_q;
    keep_d     = keep_q;
    proc_d     = 1'b0;
    proc_idx_d = proc_idx_q;
    nres_d     = nres_q;
    pend_vld_d = pend_vld_q;
    pend_val_d = pend_val_q;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = proc_idx_q;
    ram_wdata  = ram_rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_idx_d   = '0;
          keep_d     = '0;
          nres_d     = '0;
          pend_vld_d = 1'b0;
          if (in_i.kind == KIND_ADD) begin
            if (cnt_q == CntW'(DEPTH)) begin
              res_vld_d       = 1'b1;
              res_d.status    = STATUS_DROPPED;
              res_d.value_res = in_i.value;
              res_d.last      = 1'b1;
            end else begin
              ram_we             = 1'b1;
              ram_waddr          = cnt_q[IdxW-1:0];
              ram_wdata.data     = in_i.value;
              ram_wdata.lifetime = in_i.lifetime;
              ram_wdata.age      = '0;
              cnt_d              = cnt_q + CntW'(1);
            end
          end
        end
      end
      ST_TICK: begin
        if (issue) begin
          rd_idx_d   = rd_idx_q + CntW'(1);
          proc_d     = 1'b1;
          proc_idx_d = rd_idx_q[IdxW-1:0];
        end
        if (proc_q) begin
          ram_we = 1'b1;
          if (ram_rdata.age != AGE_MAX) begin
            ram_wdata.age = ram_rdata.age + AGE_W'(1);
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_d   = rd_idx_q + CntW'(1);
          proc_d     = 1'b1;
          proc_idx_d = rd_idx_q[IdxW-1:0];
        end
        if (proc_q) begin
          if (expired && nres_q < NresW'(RES_LIMIT)) begin
            // hold the newest removal back until we know whether it is the last
            nres_d     = nres_q + NresW'(1);
            pend_vld_d = 1'b1;
            pend_val_d = ram_rdata.data;
            if (pend_vld_q) begin
              res_vld_d       = 1'b1;
              res_d.status    = STATUS_EXPIRED;
              res_d.value_res = pend_val_q;
              res_d.last      = 1'b0;
            end
          end else begin
            // compact in place: keep never passes the read pointer
            ram_we    = 1'b1;
            ram_waddr = keep_q[IdxW-1:0];
            keep_d    = keep_q + CntW'(1);
          end
        end
        if (walk_done) begin
          cnt_d      = keep_q;
          pend_vld_d = 1'b0;
          if (pend_vld_q) begin
            res_vld_d       = 1'b1;
            res_d.status    = STATUS_EXPIRED;
            res_d.value_res = pend_val_q;
            res_d.last      = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      rd_idx_q   <= '0;
      keep_q     <= '0;
      proc_q     <= 1'b0;
      nres_q     <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rd_idx_q   <= rd_idx_d;
      keep_q     <= keep_d;
      proc_q     <= proc_d;
      nres_q     <= nres_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q <= proc_idx_d;
    pend_val_q <= pend_val_d;
    res_q      <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

### hw/rtl/eeq_checker.sv
module eeq_checker
  import eeq_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input eeq_in_t  in_i,
  input logic     res_valid_o,
  input eeq_res_t res_o
);

  // a dropped add is reported in the cycle right after its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == STATUS_DROPPED |->
      $past(start && !busy && in_i.kind == KIND_ADD) && res_o.last
      && res_o.value_res == $past(in_i.value))
    else $error("dropped-add result without a matching add transfer");

  // removals only come out of a running scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == STATUS_EXPIRED |-> $past(busy))
    else $error("expired-entry result outside a scan");

  // tick and scan walk the queue, so busy follows the transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (in_i.kind == KIND_TICK || in_i.kind == KIND_SCAN) |=> busy)
    else $error("tick or scan transfer did not raise busy");

  // an add never raises busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.kind == KIND_ADD |=> !busy)
    else $error("add transfer raised busy");

  // a non-final removal is always followed by another result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("non-final result after the scan ended");

endmodule

bind expiring_entry_queue eeq_checker u_eeq_checker (.*);

### tb/testbench.sv
module testbench;
  import eeq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 186;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  eeq_in_t  cmd = '0;
  logic     res_valid_o;
  eeq_res_t res_o;

  // shadow copy of the held entries, in insertion order
  logic [DATA_W-1:0] held_data [EEQ_DEPTH];
  logic [LIFE_W-1:0] held_life [EEQ_DEPTH];
  logic [AGE_W-1:0]  held_age  [EEQ_DEPTH];
  int unsigned       held_count = 0;

  eeq_res_t    expected_reports [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          burst = 1'b0;

  expiring_entry_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (cmd),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic eeq_in_t make_item(logic [1:0] kind, logic [DATA_W-1:0] value,
                                        logic [LIFE_W-1:0] lifetime);
    eeq_in_t item;
    item.kind = kind;
    item.value = value;
    item.lifetime = lifetime;
    return item;
  endfunction

  task automatic push_report(logic status, logic [DATA_W-1:0] value, logic last);
    eeq_res_t r;
    r.status = status;
    r.value_res = value;
    r.last = last;
    expected_reports.push_back(r);
  endtask

  task automatic predict_reports(input eeq_in_t item);
    int unsigned kept;
    int unsigned n;
    kept = 0;
    n = 0;
    case (item.kind)
      KIND_ADD: begin
        if (held_count >= EEQ_DEPTH) begin
          push_report(STATUS_DROPPED, item.value, 1'b1);
        end else begin
          held_data[held_count] = item.value;
          held_life[held_count] = item.lifetime;
          held_age[held_count] = '0;
          held_count++;
        end
      end
      KIND_TICK: begin
        for (int unsigned i = 0; i < held_count; i++)
          if (held_age[i] != AGE_MAX) held_age[i]++;
      end
      KIND_SCAN: begin
        for (int unsigned i = 0; i < held_count; i++) begin
          if (held_age[i] > held_life[i] && n < RES_LIMIT) begin
            push_report(STATUS_EXPIRED, held_data[i], 1'b0);
            n++;
          end else begin
            held_data[kept] = held_data[i];
            held_life[kept] = held_life[i];
            held_age[kept] = held_age[i];
            kept++;
          end
        end
        held_count = kept;
        if (n > 0) expected_reports[expected_reports.size()-1].last = 1'b1;
      end
      default: ;  // unknown kind leaves everything alone
    endcase
  endtask

  task automatic note_mismatch(string what, eeq_res_t want, eeq_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected status %0d value %0d last %0d, got status %0d value %0d last %0d",
               what, want.status, want.value_res, want.last,
               got.status, got.value_res, got.last);
  endtask

  always @(posedge clk_i) begin : check_reports
    eeq_res_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_reports.size() == 0) begin
        note_mismatch("result with nothing expected", '0, res_o);
      end else begin
        want = expected_reports.pop_front();
        if (res_o.status !== want.status || res_o.value_res !== want.value_res ||
            res_o.last !== want.last)
          note_mismatch("result mismatch", want, res_o);
      end
    end
  end

  function automatic int unsigned idle_gap();
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  // start stays high across back-to-back items, so it is only lowered for a gap
  task automatic send_item(input eeq_in_t item, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd <= item;
    do @(posedge clk_i); while (busy);
    predict_reports(item);
  endtask

  task automatic wait_for_idle();
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    while ((expected_reports.size() != 0 || busy) && guard < 4000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (EEQ_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic test_empty_queue();
    send_item(make_item(KIND_SCAN, $urandom(), 16'($urandom())), idle_gap());
    send_item(make_item(KIND_TICK, $urandom(), 16'($urandom())), idle_gap());
    send_item(make_item(KIND_RSVD, $urandom(), 16'($urandom())), idle_gap());
    send_item(make_item(KIND_SCAN, $urandom(), 16'($urandom())), idle_gap());
  endtask

  task automatic test_full_queue();
    logic [DATA_W-1:0] v;
    for (int i = 0; i < EEQ_DEPTH; i++) begin
      case (i)
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        3: v = 32'hffff_ffff;
        default: v = $urandom();
      endcase
      send_item(make_item(KIND_ADD, v, '0), idle_gap());
    end
    // full: dropped and reported, held entries untouched
    send_item(make_item(KIND_ADD, $urandom(), 16'hffff), idle_gap());
    send_item(make_item(KIND_RSVD, 32'hffff_ffff, 16'hffff), idle_gap());
    send_item(make_item(KIND_SCAN, $urandom(), 16'($urandom())), idle_gap());
    send_item(make_item(KIND_TICK, $urandom(), 16'($urandom())), idle_gap());
    // every entry expired: the largest scan
    send_item(make_item(KIND_SCAN, $urandom(), 16'($urandom())), idle_gap());
  endtask

  task automatic test_expiry_boundary();
    send_item(make_item(KIND_ADD, $urandom(), 16'd1), idle_gap());
    send_item(make_item(KIND_ADD, $urandom(), 16'hffff), idle_gap());
    send_item(make_item(KIND_ADD, $urandom(), 16'd2), idle_gap());
    // age equal to lifetime is not yet expired
    send_item(make_item(KIND_TICK, $urandom(), 16'($urandom())), idle_gap());
    send_item(make_item(KIND_SCAN, $urandom(), 16'($urandom())), idle_gap());
    send_item(make_item(KIND_TICK, $urandom(), 16'($urandom())), idle_gap());
    send_item(make_item(KIND_SCAN, $urandom(), 16'($urandom())), idle_gap());
    send_item(make_item(KIND_TICK, $urandom(), 16'($urandom())), idle_gap());
    send_item(make_item(KIND_SCAN, $urandom(), 16'($urandom())), idle_gap());
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    logic [1:0]  kind;
    logic [LIFE_W-1:0] life;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 16 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) wait_for_idle();
      pick = $urandom_range(0, 99);
      if (pick < 50) kind = KIND_ADD;
      else if (pick < 75) kind = KIND_TICK;
      else if (pick < 95) kind = KIND_SCAN;
      else kind = KIND_RSVD;
      // short lifetimes keep entries expiring so the queue churns
      life = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4));
      send_item(make_item(kind, $urandom(), life), idle_gap());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_full_queue();
    test_expiry_boundary();
    test_random_traffic();
    wait_for_idle();
    mismatches += expected_reports.size();
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
